FILE: sv/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Holds the operation codes, the result class and the default widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    // Width of each operand and result field on the stream ports.
    localparam int FIELD_W          = 32;
    localparam int DATA_WIDTH_DEF   = 32;
    localparam int FRAC_BITS_DEF    = 16;

    // Operation codes carried in the input tuser.
    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_CONJ = 3'd4
    } op_t;

    // How the final stage treats the carried value.
    typedef enum logic [1:0] {
        KIND_VAL = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2
    } kind_t;

endpackage

`default_nettype wire

FILE: sv/cau_div_pipe.sv
// ----------------------------------------------------------------------------
// cau_div_pipe: pipelined restoring divider
// One quotient bit per register stage, most significant bit first. Each stage
// loads when its enable is high, so the pipeline stalls with the control path.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int QW = 33,   // quotient bits
    parameter int CW = 116,  // remainder width
    parameter int DW = 65    // divisor width
) (
    input  wire logic          aclk,
    input  wire logic [QW-1:0] en,
    input  wire logic [CW-1:0] in_rem,
    input  wire logic [DW-1:0] in_den,
    output logic      [QW-1:0] q_out
);

    logic [CW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            localparam int K = QW - 1 - j;
            logic [CW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] q_in;
            logic [CW:0]   diff;

            if (j == 0) begin : g_first
                assign rem_in = in_rem;
                assign den_in = in_den;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = rem_reg[j-1];
                assign den_in = den_reg[j-1];
                assign q_in   = q_reg[j-1];
            end

            // A clear top bit means the shifted divisor fits into the remainder.
            assign diff = {1'b0, rem_in} - ((CW+1)'(den_in) << K);

            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    den_reg[j] <= den_in;
                    if (!diff[CW]) begin
                        rem_reg[j] <= diff[CW-1:0];
                        q_reg[j]   <= q_in | (QW'(1) << K);
                    end else begin
                        rem_reg[j] <= rem_in;
                        q_reg[j]   <= q_in;
                    end
                end
            end
        end
    endgenerate

    assign q_out = q_reg[QW-1];

endmodule

`default_nettype wire

FILE: sv/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit: pipelined complex add, subtract, multiply, divide, conjugate
// Signed fixed-point complex arithmetic on stream channels, one result per item.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock while the result side keeps up, and
// returns one result transfer for each, in order. Every item goes through the
// same pipeline of DATA_WIDTH + 6 register stages (38 at the default width): an
// input stage, a product stage, a sum stage, a rounding and divider setup stage,
// one stage for each of the DATA_WIDTH + 1 quotient bits of the restoring
// divider, and the output register. The sustained rate is one item per cycle
// while the result side does not stall. Each stage moves whenever it is empty or
// the stage after it moves, so a stall on the result side fills bubbles first and
// no item is lost or repeated. Multiply and divide round to nearest with ties
// away from zero; all results saturate to the signed range and raise the
// saturated flag. A divide by zero gives a zero result with div_by_zero set, and
// undefined operation codes give zero with both flags clear.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [4*FIELD_W-1:0] s_tdata,  // a_re, a_im, b_re, b_im
    input  wire logic [2:0]           s_tuser,  // req_type
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [2*FIELD_W-1:0]      m_tdata,  // res_re, res_im
    output logic [1:0]                m_tuser   // div_by_zero, saturated
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int VW = 2 * W + 2;
    localparam int DW = SW;
    localparam int NW = SW + F + 1;
    localparam int CW = 3 * W + F + 3;
    localparam int QW = W + 1;
    localparam int NS = 4 + QW;          // stages before the output register

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = !m_tvalid || m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ---------------- Stage 0: operand capture ----------------
    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [2:0]          op_reg;

    function automatic logic signed [W-1:0] take_field(input logic [FIELD_W-1:0] f);
        if (W <= FIELD_W) begin
            take_field = signed'(W'(f));
        end else begin
            take_field = W'(signed'(f));
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            a_reg  <= take_field(s_tdata[0*FIELD_W +: FIELD_W]);
            b_reg  <= take_field(s_tdata[1*FIELD_W +: FIELD_W]);
            c_reg  <= take_field(s_tdata[2*FIELD_W +: FIELD_W]);
            d_reg  <= take_field(s_tdata[3*FIELD_W +: FIELD_W]);
            op_reg <= s_tuser;
        end
    end

    // ---------------- Stage 1: products and simple results ----------------
    logic signed [PW-1:0] p_ac_reg, p_bd_reg, p_ad_reg, p_bc_reg, p_cc_reg, p_dd_reg;
    logic signed [VW-1:0] s1_re_reg, s1_im_reg, s1_re_next, s1_im_next;
    kind_t                s1_kind_reg, s1_kind_next;
    logic                 s1_divz_reg, s1_divz_next;

    always_comb begin
        s1_re_next   = '0;
        s1_im_next   = '0;
        s1_kind_next = KIND_VAL;
        s1_divz_next = 1'b0;
        case (op_reg)
            OP_ADD: begin
                s1_re_next = VW'(a_reg) + VW'(c_reg);
                s1_im_next = VW'(b_reg) + VW'(d_reg);
            end
            OP_SUB: begin
                s1_re_next = VW'(a_reg) - VW'(c_reg);
                s1_im_next = VW'(b_reg) - VW'(d_reg);
            end
            OP_MUL: s1_kind_next = KIND_MUL;
            OP_DIV: begin
                if (c_reg == '0 && d_reg == '0) begin
                    s1_divz_next = 1'b1;
                end else begin
                    s1_kind_next = KIND_DIV;
                end
            end
            OP_CONJ: begin
                s1_re_next = VW'(a_reg);
                s1_im_next = -VW'(b_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            p_ac_reg    <= PW'(a_reg) * PW'(c_reg);
            p_bd_reg    <= PW'(b_reg) * PW'(d_reg);
            p_ad_reg    <= PW'(a_reg) * PW'(d_reg);
            p_bc_reg    <= PW'(b_reg) * PW'(c_reg);
            p_cc_reg    <= PW'(c_reg) * PW'(c_reg);
            p_dd_reg    <= PW'(d_reg) * PW'(d_reg);
            s1_re_reg   <= s1_re_next;
            s1_im_reg   <= s1_im_next;
            s1_kind_reg <= s1_kind_next;
            s1_divz_reg <= s1_divz_next;
        end
    end

    // ---------------- Stage 2: sums of products ----------------
    logic signed [VW-1:0] s2_re_reg, s2_im_reg, s2_re_next, s2_im_next;
    logic [DW-1:0]        s2_den_reg;
    kind_t                s2_kind_reg;
    logic                 s2_divz_reg;

    always_comb begin
        case (s1_kind_reg)
            KIND_MUL: begin
                s2_re_next = VW'(SW'(p_ac_reg) - SW'(p_bd_reg));
                s2_im_next = VW'(SW'(p_ad_reg) + SW'(p_bc_reg));
            end
            KIND_DIV: begin
                s2_re_next = VW'(SW'(p_ac_reg) + SW'(p_bd_reg));
                s2_im_next = VW'(SW'(p_bc_reg) - SW'(p_ad_reg));
            end
            default: begin
                s2_re_next = s1_re_reg;
                s2_im_next = s1_im_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_re_reg   <= s2_re_next;
            s2_im_reg   <= s2_im_next;
            s2_den_reg  <= DW'($unsigned(SW'(p_cc_reg) + SW'(p_dd_reg)));
            s2_kind_reg <= s1_kind_reg;
            s2_divz_reg <= s1_divz_reg;
        end
    end

    // ---------------- Stage 3: product rounding and divider setup ----------------
    logic [VW-1:0]        mag_re, mag_im;
    logic signed [VW-1:0] rnd_re, rnd_im;
    logic [CW-1:0]        num_re, num_im, den_top;

    assign mag_re = s2_re_reg[VW-1] ? VW'(-s2_re_reg) : VW'(s2_re_reg);
    assign mag_im = s2_im_reg[VW-1] ? VW'(-s2_im_reg) : VW'(s2_im_reg);

    generate
        if (F > 0) begin : g_round
            logic [VW-1:0] sh_re, sh_im;
            assign sh_re  = (mag_re + (VW'(1) << (F - 1))) >> F;
            assign sh_im  = (mag_im + (VW'(1) << (F - 1))) >> F;
            assign rnd_re = s2_re_reg[VW-1] ? -signed'(sh_re) : signed'(sh_re);
            assign rnd_im = s2_im_reg[VW-1] ? -signed'(sh_im) : signed'(sh_im);
        end else begin : g_noround
            assign rnd_re = s2_re_reg;
            assign rnd_im = s2_im_reg;
        end
    endgenerate

    assign num_re  = CW'(NW'(mag_re) << (F + 1));
    assign num_im  = CW'(NW'(mag_im) << (F + 1));
    assign den_top = CW'(s2_den_reg) << QW;

    logic signed [VW-1:0] s3_v_re_reg, s3_v_im_reg;
    logic [CW-1:0]        s3_num_re_reg, s3_num_im_reg;
    logic [DW-1:0]        s3_den_reg;
    kind_t                s3_kind_reg;
    logic                 s3_divz_reg;
    logic                 s3_neg_re_reg, s3_neg_im_reg, s3_ovf_re_reg, s3_ovf_im_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_v_re_reg   <= (s2_kind_reg == KIND_MUL) ? rnd_re : s2_re_reg;
            s3_v_im_reg   <= (s2_kind_reg == KIND_MUL) ? rnd_im : s2_im_reg;
            s3_num_re_reg <= num_re;
            s3_num_im_reg <= num_im;
            s3_den_reg    <= s2_den_reg;
            s3_kind_reg   <= s2_kind_reg;
            s3_divz_reg   <= s2_divz_reg;
            s3_neg_re_reg <= s2_re_reg[VW-1];
            s3_neg_im_reg <= s2_im_reg[VW-1];
            // Quotients of 2^QW or more always saturate; the output stage then ignores q.
            s3_ovf_re_reg <= num_re >= den_top;
            s3_ovf_im_reg <= num_im >= den_top;
        end
    end

    // ---------------- Divider stages ----------------
    logic [QW-1:0] q_re, q_im;

    cau_div_pipe #(.QW(QW), .CW(CW), .DW(DW)) u_div_re (
        .aclk   (aclk),
        .en     (adv[4 +: QW]),
        .in_rem (s3_num_re_reg),
        .in_den (s3_den_reg),
        .q_out  (q_re)
    );

    cau_div_pipe #(.QW(QW), .CW(CW), .DW(DW)) u_div_im (
        .aclk   (aclk),
        .en     (adv[4 +: QW]),
        .in_rem (s3_num_im_reg),
        .in_den (s3_den_reg),
        .q_out  (q_im)
    );

    // Sideband that travels beside the divider.
    logic signed [VW-1:0] dv_re_reg [QW];
    logic signed [VW-1:0] dv_im_reg [QW];
    kind_t                dv_kind_reg [QW];
    logic                 dv_divz_reg [QW];
    logic                 dv_neg_re_reg [QW];
    logic                 dv_neg_im_reg [QW];
    logic                 dv_ovf_re_reg [QW];
    logic                 dv_ovf_im_reg [QW];

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            dv_re_reg[0]     <= s3_v_re_reg;
            dv_im_reg[0]     <= s3_v_im_reg;
            dv_kind_reg[0]   <= s3_kind_reg;
            dv_divz_reg[0]   <= s3_divz_reg;
            dv_neg_re_reg[0] <= s3_neg_re_reg;
            dv_neg_im_reg[0] <= s3_neg_im_reg;
            dv_ovf_re_reg[0] <= s3_ovf_re_reg;
            dv_ovf_im_reg[0] <= s3_ovf_im_reg;
        end
        for (int j = 1; j < QW; j++) begin
            if (adv[4+j]) begin
                dv_re_reg[j]     <= dv_re_reg[j-1];
                dv_im_reg[j]     <= dv_im_reg[j-1];
                dv_kind_reg[j]   <= dv_kind_reg[j-1];
                dv_divz_reg[j]   <= dv_divz_reg[j-1];
                dv_neg_re_reg[j] <= dv_neg_re_reg[j-1];
                dv_neg_im_reg[j] <= dv_neg_im_reg[j-1];
                dv_ovf_re_reg[j] <= dv_ovf_re_reg[j-1];
                dv_ovf_im_reg[j] <= dv_ovf_im_reg[j-1];
            end
        end
    end

    // ---------------- Output stage: quotient rounding and saturation ----------------
    localparam logic signed [VW-1:0] HI = (VW'(1) <<< (W - 1)) - VW'(1);
    localparam logic signed [VW-1:0] LO = -HI - VW'(1);

    function automatic logic [W:0] clamp(input logic signed [VW-1:0] v);
        // Returns {clamped flag, value}.
        if (v > HI) begin
            clamp = {1'b1, HI[W-1:0]};
        end else if (v < LO) begin
            clamp = {1'b1, LO[W-1:0]};
        end else begin
            clamp = {1'b0, v[W-1:0]};
        end
    endfunction

    function automatic logic signed [VW-1:0] finish(
        input kind_t                k,
        input logic signed [VW-1:0] v,
        input logic [QW-1:0]        q,
        input logic                 neg,
        input logic                 ovf
    );
        logic [QW:0]   q1;
        logic [VW-1:0] mag;
        q1  = ({1'b0, q} + (QW+1)'(1)) >> 1;
        mag = VW'(q1);
        if (k != KIND_DIV) begin
            finish = v;
        end else if (ovf) begin
            finish = neg ? LO - VW'(1) : HI + VW'(1);
        end else begin
            finish = neg ? -signed'(mag) : signed'(mag);
        end
    endfunction

    logic [W:0] cl_re, cl_im;

    assign cl_re = clamp(finish(dv_kind_reg[QW-1], dv_re_reg[QW-1], q_re,
                                dv_neg_re_reg[QW-1], dv_ovf_re_reg[QW-1]));
    assign cl_im = clamp(finish(dv_kind_reg[QW-1], dv_im_reg[QW-1], q_im,
                                dv_neg_im_reg[QW-1], dv_ovf_im_reg[QW-1]));

    logic                m_tvalid_reg;
    logic [W-1:0]        res_re_reg, res_im_reg;
    logic                divz_reg, sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv[NS]) begin
            m_tvalid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NS]) begin
            res_re_reg <= cl_re[W-1:0];
            res_im_reg <= cl_im[W-1:0];
            divz_reg   <= dv_divz_reg[QW-1];
            sat_reg    <= cl_re[W] || cl_im[W];
        end
    end

    assign m_tvalid = m_tvalid_reg;

    generate
        if (W >= FIELD_W) begin : g_out_trunc
            assign m_tdata = {res_im_reg[FIELD_W-1:0], res_re_reg[FIELD_W-1:0]};
        end else begin : g_out_pad
            assign m_tdata = {FIELD_W'(res_im_reg), FIELD_W'(res_re_reg)};
        end
    endgenerate

    assign m_tuser = {sat_reg, divz_reg};

endmodule

`default_nettype wire

FILE: bench/complex_arith_unit_tb.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_tb: self-checking bench for the complex arithmetic unit
// A short directed table covers the operand extremes, every operation, rounding
// ties, saturation, the zero divisor and the undefined codes. A long random
// stream follows. Each result transfer is checked against its typed-in result
// or an independent wide-integer model of the arithmetic. Random gaps on both
// sides and one long result-side stall exercise backpressure through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam int N_RANDOM    = 830;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;   // comfortably above the pipeline latency
    localparam int HOLD_OFF    = 400;  // long enough to fill every stage
    localparam logic [2:0] OP_UNDEF5 = 3'd5;
    localparam logic [2:0] OP_UNDEF6 = 3'd6;
    localparam logic [2:0] OP_UNDEF7 = 3'd7;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } cplx_res_t;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] ar, ai, br, bi;
        bit          fixed;   // expected result typed in below
        logic [31:0] er, ei;
        logic        ez, es;
    } vec_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [4*FIELD_W-1:0] s_tdata;   // a_re, a_im, b_re, b_im
    logic [2:0]           s_tuser;   // req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [2*FIELD_W-1:0] m_tdata;   // res_re, res_im
    logic [1:0]           m_tuser;   // div_by_zero, saturated

    cplx_res_t pending_results[$];
    int        n_errors;
    int        n_sent;
    bit        sending_done;
    longint    cycle_cnt;
    vec_t      dir_vecs [17];

    complex_arith_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Clamp a wide value to the signed 32-bit range, noting any clamp.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end else if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Drop the extra fraction bits of a product, nearest with ties away from zero.
    function automatic logic signed [127:0] round_prod(input logic signed [127:0] v);
        logic signed [127:0] mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (128'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
        return (v < 0) ? -mag : mag;
    endfunction

    // num * 2^FRAC / den, nearest with ties away from zero; den is positive.
    function automatic logic signed [127:0] round_quot(input logic signed [127:0] num,
                                                       input logic signed [127:0] den);
        logic signed [127:0] q;
        q = ((num < 0) ? -num : num) <<< (FRAC_BITS_DEF + 1);
        q = ((q / den) + 128'sd1) >>> 1;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_res_t cplx_result(input logic [2:0] op,
                                              input logic signed [31:0] ar, ai, br, bi);
        logic signed [127:0] a, b, c, d, re, im, den;
        cplx_res_t r;
        a = ar; b = ai; c = br; d = bi;
        re = '0; im = '0;
        r.dz = 1'b0; r.sat = 1'b0;
        case (op)
            OP_ADD:  begin re = a + c; im = b + d; end
            OP_SUB:  begin re = a - c; im = b - d; end
            OP_MUL: begin
                re = round_prod(a * c - b * d);
                im = round_prod(a * d + b * c);
            end
            OP_DIV: begin
                if (c == 0 && d == 0) begin
                    r.dz = 1'b1;
                end else begin
                    den = c * c + d * d;
                    re = round_quot(a * c + b * d, den);
                    im = round_quot(b * c - a * d, den);
                end
            end
            OP_CONJ: begin re = a; im = -b; end
            default: ;
        endcase
        r.re = clamp32(re, r.sat);
        r.im = clamp32(im, r.sat);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3, 4:    return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
            5:       return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until the unit takes it.
    task automatic send_item(input logic [2:0] op, input logic [31:0] ar, ai, br, bi,
                             input bit fixed, input cplx_res_t want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {bi, br, ai, ar};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(fixed ? want : cplx_result(op, ar, ai, br, bi));
        n_sent++;
        @(negedge aclk);
    endtask

    initial begin
        dir_vecs = '{
            '{OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 0, 0},
            '{OP_ADD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              1, 32'h7fffffff, 32'h7fffffff, 0, 1},
            '{OP_SUB, 32'h80000000, 32'h80000000, 32'h1, 32'h1,
              1, 32'h80000000, 32'h80000000, 0, 1},
            '{OP_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              1, 32'h7fffffff, 32'h80000000, 0, 1},
            '{OP_MUL, 32'h10000, 32'h0, 32'h20000, 32'h0, 0, 0, 0, 0, 0},
            '{OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              0, 0, 0, 0, 0},
            '{OP_MUL, 32'h1, 32'h0, 32'h8000, 32'h0, 0, 0, 0, 0, 0},
            '{OP_MUL, 32'hffffffff, 32'h0, 32'h8000, 32'h0, 0, 0, 0, 0, 0},
            '{OP_DIV, 32'h10000, 32'h10000, 32'h0, 32'h0, 1, 32'h0, 32'h0, 1, 0},
            '{OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0, 0, 0, 0, 0, 0},
            '{OP_DIV, 32'h30000, 32'h40000, 32'h10000, 32'h20000, 0, 0, 0, 0, 0},
            '{OP_DIV, 32'h7fffffff, 32'h1, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0},
            '{OP_CONJ, 32'h5, 32'h80000000, 32'h1234, 32'h5678,
              1, 32'h5, 32'h7fffffff, 0, 1},
            '{OP_CONJ, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0,
              1, 32'h7fffffff, 32'h80000001, 0, 0},
            '{OP_UNDEF5, 32'h7fffffff, 32'h1, 32'h2, 32'h3, 1, 32'h0, 32'h0, 0, 0},
            '{OP_UNDEF6, 32'h80000000, 32'hffffffff, 32'h0, 32'h0, 1, 32'h0, 32'h0, 0, 0},
            '{OP_UNDEF7, 32'h12345678, 32'h9abcdef0, 32'h1, 32'h1, 1, 32'h0, 32'h0, 0, 0}
        };
    end

    // Sender: reset, the directed table, then the random stream.
    initial begin
        cplx_res_t want;
        logic [2:0] op;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        n_sent   = 0;
        sending_done = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        foreach (dir_vecs[i]) begin
            want = '{dir_vecs[i].er, dir_vecs[i].ei, dir_vecs[i].ez, dir_vecs[i].es};
            send_item(dir_vecs[i].op, dir_vecs[i].ar, dir_vecs[i].ai, dir_vecs[i].br,
                      dir_vecs[i].bi, dir_vecs[i].fixed, want);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            // Mostly defined operations, with divides weighted up; a few bad codes.
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0) op = OP_DIV;
            if (op == OP_DIV && $urandom_range(0, 9) == 0)
                send_item(op, rand_operand(), rand_operand(), 32'h0, 32'h0, 0, want);
            else
                send_item(op, rand_operand(), rand_operand(), rand_operand(),
                          rand_operand(), 0, want);
        end
        s_tvalid = 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off while items keep coming.
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && n_sent > 200) begin
                held = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
            end
            gap = (n_sent > 600 && n_sent < 700) ? 0 : gap_len();
            if (gap > 0) begin
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge aclk) begin
        cplx_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: tdata %h tuser %b", m_tdata, m_tuser);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.re) begin
                    $error("res_re: expected %h, got %h", want.re, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[63:32] !== want.im) begin
                    $error("res_im: expected %h, got %h", want.im, m_tdata[63:32]);
                    n_errors++;
                end
                if (m_tuser[0] !== want.dz) begin
                    $error("div_by_zero: expected %b, got %b", want.dz, m_tuser[0]);
                    n_errors++;
                end
                if (m_tuser[1] !== want.sat) begin
                    $error("saturated: expected %b, got %b", want.sat, m_tuser[1]);
                    n_errors++;
                end
            end
        end
    end

    // End of run: drain, allow trailing activity, report.
    initial begin
        n_errors = 0;
        wait (sending_done);
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("PASS complex_arith_unit");
        end else begin
            $display("FAIL complex_arith_unit");
        end
        $finish;
    end

    // Watchdog on total run length.
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT) begin
                $display("FAIL complex_arith_unit");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
